/* hw/rtl/csl_pkg.sv */
// shared types, codes and request tables of the compass spi link sequencer
`default_nettype none

package csl_pkg;

	// largest response frame the link is built for
	localparam int RESP_MAX = 128;
	localparam logic [7:0] FRAME_CAP = 8'((RESP_MAX < 128) ? RESP_MAX : 128);

	// event codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	// device phases
	localparam logic [1:0] PH_RESET = 2'd0;
	localparam logic [1:0] PH_INIT  = 2'd1;
	localparam logic [1:0] PH_READY = 2'd2;
	localparam logic [1:0] PH_WAIT  = 2'd3;

	// link phases
	localparam logic [1:0] LINK_IDLE  = 2'd0;
	localparam logic [1:0] LINK_READ  = 2'd1;
	localparam logic [1:0] LINK_WRITE = 2'd2;

	// request selects
	localparam logic [1:0] REQ_SETUP  = 2'd0;
	localparam logic [1:0] REQ_MODE   = 2'd1;
	localparam logic [1:0] REQ_PERIOD = 2'd2;
	localparam logic [1:0] REQ_DATA   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_WAIT_TICKS  = 2'd0;
	localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
	localparam logic [1:0] CFG_RESP_LEN    = 2'd2;
	localparam logic [1:0] CFG_PERIOD_CODE = 2'd3;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] END_BYTE  = 8'h00;
	localparam logic [7:0] FILL_BYTE = 8'h00;

	localparam logic [7:0] WAIT_TICKS_RST  = 8'd5;
	localparam logic [3:0] MAX_RETRIES_RST = 4'd10;
	localparam logic [7:0] RESP_LEN_RST    = 8'd43;
	localparam logic [7:0] PERIOD_CODE_RST = 8'd7;

	typedef struct packed {
		logic [7:0] wait_ticks;
		logic [3:0] max_retries;
		logic [7:0] response_length;
		logic [7:0] period_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] link;
		logic [1:0] setup_step;
		logic [7:0] wait_count;
		logic [1:0] req_sel;
		logic [3:0] send_index;
		logic [6:0] recv_index;
		logic [3:0] miss_count;
		logic       sync_pin;
	} state_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       select_begin;
		logic       select_end;
		logic       sync_level;
		logic       stored_valid;
		logic [6:0] stored_index;
		logic [7:0] stored_byte;
		logic       frame_done;
		logic [1:0] device_phase;
		logic [1:0] link_phase;
	} result_t;

	function automatic logic [3:0] req_len(input logic [1:0] sel);
		logic [3:0] len;
		case (sel)
			REQ_SETUP: len = 4'd10;
			REQ_DATA:  len = 4'd1;
			default:   len = 4'd3;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] req_byte(input logic [1:0] sel, input logic [3:0] idx,
			input logic [7:0] period);
		logic [7:0] b;
		case (sel)
			REQ_SETUP: begin
				case (idx)
					4'd0, 4'd10: b = 8'h03;
					4'd1, 4'd11: b = 8'h08;
					4'd2, 4'd12: b = 8'h01;
					4'd3, 4'd13: b = 8'h02;
					4'd4, 4'd14: b = 8'h03;
					4'd5, 4'd15: b = 8'h04;
					4'd6:        b = 8'h05;
					4'd7:        b = 8'h06;
					4'd8:        b = 8'h08;
					default:     b = 8'h09;
				endcase
			end
			REQ_MODE: begin
				b = (idx == 4'd0 || idx == 4'd1) ? 8'h06 : 8'h00;
			end
			REQ_PERIOD: begin
				if (idx == 4'd0)
					b = 8'h06;
				else if (idx == 4'd1)
					b = 8'h05;
				else
					b = period;
			end
			default: b = 8'h04;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/csl_cfg_regs.sv */
// configuration register file of the compass spi link sequencer
`default_nettype none

module csl_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write_en,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	output csl_pkg::cfg_t      cfg
);
	import csl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_ticks      <= WAIT_TICKS_RST;
			cfg_q.max_retries     <= MAX_RETRIES_RST;
			cfg_q.response_length <= RESP_LEN_RST;
			cfg_q.period_code     <= PERIOD_CODE_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_WAIT_TICKS:  cfg_q.wait_ticks      <= cfg_data;
				CFG_MAX_RETRIES: cfg_q.max_retries     <= cfg_data[3:0];
				CFG_RESP_LEN:    cfg_q.response_length <= cfg_data;
				CFG_PERIOD_CODE: cfg_q.period_code     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/csl_step.sv */
// next-state and result logic for one event of the compass spi link sequencer
`default_nettype none

module csl_step (
	input  wire csl_pkg::cfg_t   cfg,
	input  wire csl_pkg::state_t cur,
	input  wire logic [1:0]      operation,
	input  wire logic [7:0]      rx_byte,
	output csl_pkg::state_t      nxt,
	output csl_pkg::result_t     res
);
	import csl_pkg::*;

	logic [3:0] len;
	logic [7:0] flen;
	logic [7:0] next_idx;
	logic       take;

	always_comb begin
		len = req_len(cur.req_sel);
		flen = (cfg.response_length == 8'd0) ? 8'd1 : cfg.response_length;
		if (flen > FRAME_CAP)
			flen = FRAME_CAP;
		next_idx = {1'b0, cur.recv_index} + 8'd1;
		take = 1'b0;

		nxt = cur;
		res = '0;

		case (operation)
			OP_TICK: begin
				case (cur.phase)
					PH_RESET: begin
						nxt.sync_pin = 1'b1;
						nxt.phase = PH_INIT;
					end
					PH_INIT: begin
						if (cur.link == LINK_IDLE) begin
							if (cur.setup_step < 2'd3) begin
								nxt.req_sel = cur.setup_step;
								nxt.setup_step = cur.setup_step + 2'd1;
								nxt.link = LINK_WRITE;
								nxt.send_index = 4'd0;
								res.send_valid = 1'b1;
								res.send_byte = SYNC_BYTE;
								res.select_begin = 1'b1;
							end else begin
								nxt.phase = PH_READY;
							end
						end
					end
					PH_READY: begin
						nxt.req_sel = REQ_DATA;
						nxt.link = LINK_WRITE;
						nxt.send_index = 4'd0;
						nxt.phase = PH_WAIT;
						nxt.wait_count = 8'd0;
						res.send_valid = 1'b1;
						res.send_byte = SYNC_BYTE;
						res.select_begin = 1'b1;
					end
					default: begin
						// read starts once the wait is over and the link is free
						if (cur.wait_count >= cfg.wait_ticks && cur.link == LINK_IDLE) begin
							nxt.link = LINK_READ;
							nxt.recv_index = 7'd0;
							res.send_valid = 1'b1;
							res.send_byte = FILL_BYTE;
							res.select_begin = 1'b1;
						end
						if (cur.wait_count != 8'hFF)
							nxt.wait_count = cur.wait_count + 8'd1;
					end
				endcase
			end
			OP_BYTE: begin
				case (cur.link)
					LINK_WRITE: begin
						if (cur.send_index < len) begin
							res.send_valid = 1'b1;
							res.send_byte = req_byte(cur.req_sel, cur.send_index,
								cfg.period_code);
						end else if (cur.send_index == len) begin
							res.send_valid = 1'b1;
							res.send_byte = END_BYTE;
						end else begin
							nxt.link = LINK_IDLE;
							res.select_end = 1'b1;
						end
						if (cur.send_index != 4'hF)
							nxt.send_index = cur.send_index + 4'd1;
					end
					LINK_READ: begin
						take = 1'b1;
						// sync hunt on the first word of the frame
						if (cur.recv_index == 7'd0) begin
							if (cur.miss_count > cfg.max_retries) begin
								nxt.sync_pin = 1'b0;
								nxt.phase = PH_RESET;
								nxt.link = LINK_IDLE;
								nxt.miss_count = 4'd0;
								res.select_end = 1'b1;
								take = 1'b0;
							end else if (rx_byte != SYNC_BYTE) begin
								if (cur.miss_count != 4'hF)
									nxt.miss_count = cur.miss_count + 4'd1;
								res.send_valid = 1'b1;
								res.send_byte = FILL_BYTE;
								take = 1'b0;
							end else begin
								nxt.miss_count = 4'd0;
							end
						end
						if (take) begin
							res.stored_valid = 1'b1;
							res.stored_index = cur.recv_index;
							res.stored_byte = rx_byte;
							if (next_idx < flen) begin
								nxt.recv_index = next_idx[6:0];
								res.send_valid = 1'b1;
								res.send_byte = FILL_BYTE;
							end else begin
								nxt.recv_index = 7'd0;
								nxt.link = LINK_IDLE;
								nxt.phase = PH_READY;
								res.select_end = 1'b1;
								res.frame_done = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			OP_RESET: begin
				res.select_end = (cur.link != LINK_IDLE);
				nxt.sync_pin = 1'b0;
				nxt.phase = PH_RESET;
				nxt.link = LINK_IDLE;
			end
			default: ;
		endcase

		res.sync_level = nxt.sync_pin;
		res.device_phase = nxt.phase;
		res.link_phase = nxt.link;
	end

endmodule

`default_nettype wire

/* hw/rtl/compass_spi_link_sequencer.sv */
// top level of the compass spi link sequencer: input register, state and result register
//
// Master-side sequencer for a byte-framed SPI link to a compass module.
// Input channel (in_valid/in_ready) takes one event word: operation 0 is a
// periodic tick, 1 a finished SPI byte transfer with the byte in rx_byte,
// 2 a module reset request. Every event gives exactly one result word on
// the output channel (out_valid/out_ready): the byte to shift out, chip
// select begin/end, sync pin level, a received frame byte with its index,
// an end-of-frame flag and the device and link phases after the event.
// The input register loads at the accepting edge; the result register
// loads from it when it is empty or being taken, and a receiver stall
// can keep an event waiting in the input register. Throughput is one
// event per cycle while the receiver does not stall; the state update
// of the step logic is the only loop.
// When the receiver stalls the result register holds and one more event
// waits in the input register; in_ready drops only when both are full.
// Reset empties both registers and clears all sequencing state; the sync
// pin is low (module held in reset) and the registers return to defaults.
// Configuration is written through cfg_write_en/cfg_index/cfg_data with no wait;
// the user must write only while no event is in flight; the block does not enforce it.
`default_nettype none

module compass_spi_link_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            send_valid,
	output logic [7:0]      send_byte,
	output logic            select_begin,
	output logic            select_end,
	output logic            sync_level,
	output logic            stored_valid,
	output logic [6:0]      stored_index,
	output logic [7:0]      stored_byte,
	output logic            frame_done,
	output logic [1:0]      device_phase,
	output logic [1:0]      link_phase
);
	import csl_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_q;

	logic       valid_s1;
	logic [1:0] operation_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	logic       advance;

	csl_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	csl_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.operation (operation_s1),
		.rx_byte   (rx_byte_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// word moves into the result register when it is empty or being taken
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1 <= operation;
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign send_valid = res_q.send_valid;
	assign send_byte = res_q.send_byte;
	assign select_begin = res_q.select_begin;
	assign select_end = res_q.select_end;
	assign sync_level = res_q.sync_level;
	assign stored_valid = res_q.stored_valid;
	assign stored_index = res_q.stored_index;
	assign stored_byte = res_q.stored_byte;
	assign frame_done = res_q.frame_done;
	assign device_phase = res_q.device_phase;
	assign link_phase = res_q.link_phase;

endmodule

`default_nettype wire

/* hw/rtl/csl_checker.sv */
// port-level checks of the compass spi link sequencer and their binding
`default_nettype none

module csl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       send_valid,
	input wire logic [7:0] send_byte,
	input wire logic       select_end,
	input wire logic       sync_level,
	input wire logic       stored_valid,
	input wire logic [6:0] stored_index,
	input wire logic [7:0] stored_byte,
	input wire logic       frame_done,
	input wire logic [1:0] device_phase,
	input wire logic [1:0] link_phase
);
	import csl_pkg::*;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |-> send_byte == 8'h00)
		else $error("send byte not zero without send");

	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stored_valid |-> stored_index == 7'd0 && stored_byte == 8'h00)
		else $error("stored fields not zero without store");

	// end of frame releases the link and returns the device to ready
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> stored_valid && select_end
			&& link_phase == LINK_IDLE && device_phase == PH_READY)
		else $error("frame end without link release");

	// module in reset phase always has the sync pin low and an idle link
	a_reset_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && device_phase == PH_RESET |-> !sync_level && link_phase == LINK_IDLE)
		else $error("reset phase with sync high or busy link");

endmodule

bind compass_spi_link_sequencer csl_checker u_csl_checker (.*);

`default_nettype wire

/* test/compass_spi_link_sequencer_test.sv */
// self-checking testbench of the compass spi link sequencer: driver, monitor and predictor
`timescale 1ns / 1ps

module compass_spi_link_sequencer_test;
	import csl_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 40;
	localparam int HOLD_AFTER = 600;
	// payload bytes of the first set-up request, first byte in the top bits
	localparam logic [79:0] SETUP_PAYLOAD = 80'h03_08_01_02_03_04_05_06_08_09;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx;
	} link_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = '0;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       select_begin;
	logic       select_end;
	logic       sync_level;
	logic       stored_valid;
	logic [6:0] stored_index;
	logic [7:0] stored_byte;
	logic       frame_done;
	logic [1:0] device_phase;
	logic [1:0] link_phase;

	cfg_t        regs;
	state_t      plan_state;
	state_t      model_state;
	link_event_t event_backlog[$];
	result_t     predicted_words[$];
	result_t     seen_word;
	int          events_offered = 0;
	int          events_taken = 0;
	int          word_errors = 0;
	int          idle_cycles = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	logic        steady_window;

	compass_spi_link_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.send_valid   (send_valid),
		.send_byte    (send_byte),
		.select_begin (select_begin),
		.select_end   (select_end),
		.sync_level   (sync_level),
		.stored_valid (stored_valid),
		.stored_index (stored_index),
		.stored_byte  (stored_byte),
		.frame_done   (frame_done),
		.device_phase (device_phase),
		.link_phase   (link_phase)
	);

	always #1 clk = ~clk;

	assign seen_word = {send_valid, send_byte, select_begin, select_end, sync_level,
		stored_valid, stored_index, stored_byte, frame_done, device_phase, link_phase};

	// neither side idles while this many words go through
	assign steady_window = (events_taken >= 300) && (events_taken < 500);

	function automatic logic [3:0] request_length(input logic [1:0] sel);
		case (sel)
			REQ_SETUP: return 4'd10;
			REQ_DATA:  return 4'd1;
			default:   return 4'd3;
		endcase
	endfunction

	function automatic logic [7:0] request_byte(input logic [1:0] sel, input logic [3:0] i);
		case (sel)
			REQ_SETUP:  return SETUP_PAYLOAD[79 - 8 * i -: 8];
			REQ_MODE:   return (i < 4'd2) ? 8'h06 : 8'h00;
			REQ_PERIOD: return (i == 4'd0) ? 8'h06 : (i == 4'd1) ? 8'h05 : regs.period_code;
			default:    return 8'h04;
		endcase
	endfunction

	function automatic logic [7:0] frame_bytes();
		logic [7:0] n;
		n = (regs.response_length == 8'd0) ? 8'd1 : regs.response_length;
		return (n > FRAME_CAP) ? FRAME_CAP : n;
	endfunction

	function automatic void hold_module(inout state_t s);
		s.sync_pin = 1'b0;
		s.phase = PH_RESET;
		s.link = LINK_IDLE;
	endfunction

	function automatic result_t advance_sequencer(inout state_t s, input logic [1:0] op,
			input logic [7:0] rx);
		result_t    r;
		logic [3:0] len;
		logic [7:0] pos;
		logic       keep;
		r = '0;
		case (op)
			OP_TICK: begin
				case (s.phase)
					PH_RESET: begin
						s.sync_pin = 1'b1;
						s.phase = PH_INIT;
					end
					PH_INIT: begin
						if (s.link == LINK_IDLE) begin
							if (s.setup_step != 2'd3) begin
								s.req_sel = s.setup_step;
								s.setup_step = s.setup_step + 2'd1;
								s.link = LINK_WRITE;
								s.send_index = '0;
								r.send_valid = 1'b1;
								r.send_byte = SYNC_BYTE;
								r.select_begin = 1'b1;
							end else begin
								s.phase = PH_READY;
							end
						end
					end
					PH_READY: begin
						s.req_sel = REQ_DATA;
						s.link = LINK_WRITE;
						s.send_index = '0;
						r.send_valid = 1'b1;
						r.send_byte = SYNC_BYTE;
						r.select_begin = 1'b1;
						s.phase = PH_WAIT;
						s.wait_count = '0;
					end
					default: begin
						// the read starts once, and only with the link free
						if (s.wait_count >= regs.wait_ticks && s.link == LINK_IDLE) begin
							s.link = LINK_READ;
							s.recv_index = '0;
							r.send_valid = 1'b1;
							r.send_byte = FILL_BYTE;
							r.select_begin = 1'b1;
						end
						if (s.wait_count != 8'hFF)
							s.wait_count = s.wait_count + 8'd1;
					end
				endcase
			end
			OP_BYTE: begin
				if (s.link == LINK_WRITE) begin
					len = request_length(s.req_sel);
					if (s.send_index < len) begin
						r.send_valid = 1'b1;
						r.send_byte = request_byte(s.req_sel, s.send_index);
					end else if (s.send_index == len) begin
						r.send_valid = 1'b1;
						r.send_byte = END_BYTE;
					end else begin
						s.link = LINK_IDLE;
						r.select_end = 1'b1;
					end
					if (s.send_index != 4'd15)
						s.send_index = s.send_index + 4'd1;
				end else if (s.link == LINK_READ) begin
					keep = 1'b1;
					if (s.recv_index == 7'd0) begin
						if (s.miss_count > regs.max_retries) begin
							hold_module(s);
							s.miss_count = '0;
							r.select_end = 1'b1;
							keep = 1'b0;
						end else if (rx != SYNC_BYTE) begin
							if (s.miss_count != 4'd15)
								s.miss_count = s.miss_count + 4'd1;
							r.send_valid = 1'b1;
							r.send_byte = FILL_BYTE;
							keep = 1'b0;
						end else begin
							s.miss_count = '0;
						end
					end
					if (keep) begin
						r.stored_valid = 1'b1;
						r.stored_index = s.recv_index;
						r.stored_byte = rx;
						pos = {1'b0, s.recv_index} + 8'd1;
						if (pos < frame_bytes()) begin
							s.recv_index = pos[6:0];
							r.send_valid = 1'b1;
							r.send_byte = FILL_BYTE;
						end else begin
							s.recv_index = '0;
							s.link = LINK_IDLE;
							s.phase = PH_READY;
							r.select_end = 1'b1;
							r.frame_done = 1'b1;
						end
					end
				end
			end
			OP_RESET: begin
				if (s.link != LINK_IDLE)
					r.select_end = 1'b1;
				hold_module(s);
			end
			default: ;
		endcase
		r.sync_level = s.sync_pin;
		r.device_phase = s.phase;
		r.link_phase = s.link;
		return r;
	endfunction

	function automatic string show_word(input result_t r);
		return $sformatf({"send %0b/%02h begin %0b end %0b sync %0b store %0b/%0d/%02h ",
			"done %0b phase %0d link %0d"}, r.send_valid, r.send_byte, r.select_begin,
			r.select_end, r.sync_level, r.stored_valid, r.stored_index, r.stored_byte,
			r.frame_done, r.device_phase, r.link_phase);
	endfunction

	task automatic plan_event(input logic [1:0] op, input logic [7:0] rx);
		link_event_t ev;
		ev.op = op;
		ev.rx = rx;
		void'(advance_sequencer(plan_state, op, rx));
		event_backlog.push_back(ev);
	endtask

	// mostly events that move the link along, with some noise and reset requests
	task automatic queue_events(input int count, input int reset_pct);
		int         n;
		int         roll;
		logic [1:0] op;
		logic [7:0] rx;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			rx = 8'($urandom_range(0, 255));
			if (roll < reset_pct)
				op = OP_RESET;
			else if (roll < reset_pct + 2)
				op = OP_SPARE;
			else if (roll < 12)
				op = 2'($urandom_range(0, 1));
			else if (plan_state.link == LINK_IDLE)
				op = OP_TICK;
			else begin
				op = OP_BYTE;
				if (plan_state.link == LINK_READ && plan_state.recv_index == 7'd0
						&& $urandom_range(0, 3) != 0)
					rx = SYNC_BYTE;
			end
			plan_event(op, rx);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_WAIT_TICKS:  regs.wait_ticks = value;
			CFG_MAX_RETRIES: regs.max_retries = value[3:0];
			CFG_RESP_LEN:    regs.response_length = value;
			default:         regs.period_code = value;
		endcase
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic write_all(input logic [7:0] wait_ticks, input logic [3:0] retries,
			input logic [7:0] resp_len, input logic [7:0] period);
		write_reg(CFG_WAIT_TICKS, wait_ticks);
		// upper bits of the retry limit are junk that must be dropped
		write_reg(CFG_MAX_RETRIES, {4'($urandom_range(0, 15)), retries});
		write_reg(CFG_RESP_LEN, resp_len);
		write_reg(CFG_PERIOD_CODE, period);
	endtask

	task automatic drain();
		while (event_backlog.size() != 0 || events_taken != events_offered
				|| predicted_words.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin : drive_events
		link_event_t ev;
		if (arst_n && events_taken == events_offered) begin
			if (event_backlog.size() != 0 && (steady_window || $urandom_range(0, 99) >= 16)) begin
				ev = event_backlog.pop_front();
				in_valid <= 1'b1;
				operation <= ev.op;
				rx_byte <= ev.rx;
				events_offered <= events_offered + 1;
			end else begin
				in_valid <= 1'b0;
				operation <= 2'($urandom_range(0, 3));
				rx_byte <= 8'($urandom_range(0, 255));
			end
		end
	end

	// receiver, with one long hold-off so the block backs up
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && events_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady_window || $urandom_range(0, 99) >= 16;
		end
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (in_valid && in_ready) begin
			predicted_words.push_back(advance_sequencer(model_state, operation, rx_byte));
			events_taken = events_taken + 1;
		end
		if (out_valid && out_ready) begin
			if (predicted_words.size() == 0) begin
				word_errors = word_errors + 1;
				if (word_errors <= 10)
					$display("unexpected result word: %s", show_word(seen_word));
			end else begin
				want = predicted_words.pop_front();
				if (seen_word !== want) begin
					word_errors = word_errors + 1;
					if (word_errors <= 10)
						$display("result word mismatch\n  expected %s\n  actual   %s",
							show_word(want), show_word(seen_word));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		regs = {WAIT_TICKS_RST, MAX_RETRIES_RST, RESP_LEN_RST, PERIOD_CODE_RST};
		plan_state = '0;
		model_state = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the period code only goes out once, in the set-up after power-up
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_PERIOD_CODE, 8'($urandom_range(0, 255)));

		// directed opening: spare op, byte while idle, reset requests in both link states
		plan_event(OP_SPARE, 8'hFF);
		plan_event(OP_BYTE, 8'h00);
		plan_event(OP_RESET, 8'hFF);
		plan_event(OP_TICK, 8'h00);
		plan_event(OP_TICK, 8'hFF);
		plan_event(OP_BYTE, SYNC_BYTE);
		plan_event(OP_BYTE, 8'h00);
		plan_event(OP_BYTE, 8'hFF);
		plan_event(OP_RESET, 8'h55);
		plan_event(OP_TICK, 8'hAB);
		plan_event(OP_TICK, 8'h54);
		plan_event(OP_TICK, 8'h01);
		plan_event(OP_BYTE, 8'h80);
		queue_events(110, 2);
		drain();

		// shortest wait, one miss allowed before a module reset, one-byte frames
		write_all(8'd0, 4'd0, 8'd1, 8'hFF);
		queue_events(110, 3);
		drain();

		// longest wait and frame, retries never run out
		write_all(8'd255, 4'd15, 8'd128, 8'h00);
		queue_events(460, 0);
		drain();

		// zero frame length acts as one
		write_all(8'd1, 4'd3, 8'd0, 8'h5A);
		queue_events(110, 2);
		drain();

		// frame length beyond the cap
		write_all(8'd2, 4'd1, 8'd200, 8'hA5);
		queue_events(170, 1);
		drain();

		write_all(8'($urandom_range(0, 6)), 4'($urandom_range(0, 15)),
			8'($urandom_range(1, 24)), 8'($urandom_range(0, 255)));
		queue_events(110, 2);
		drain();

		repeat (8) @(posedge clk);
		if (word_errors == 0 && predicted_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
